// File: hw/rtl/pcsc_pkg.sv
// ----------------------------------------------------------------------------
// pcsc_pkg: shared types, constants and cube edge tables
// Word layouts, sequencer states and the serial unit request/status types.
// ----------------------------------------------------------------------------
package pcsc_pkg;

    localparam int          EDGES           = 12;
    localparam int          MIN_POINTS      = 3;
    localparam int          WINDOW_SIZE_DEF = 131072;
    localparam logic [16:0] ONE_Q16         = 17'd65536;
    localparam int          RAD_W           = 64;   // radicand / dividend width
    localparam int          DEN_W           = 32;   // divisor width
    localparam int          RES_W           = 48;   // quotient register width
    localparam logic [5:0]  QB_EDGE         = 6'd17;
    localparam logic [5:0]  QB_CTR          = 6'd17;
    localparam logic [5:0]  QB_VEC          = 6'd18;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] plane_offset;
    } t_in_word;

    typedef struct packed {
        logic               valid_res;
        logic        [1:0]  corner_index;
        logic signed [19:0] corner_x;
        logic signed [19:0] corner_y;
        logic signed [19:0] corner_z;
        logic               last;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_CTR,
        S_DIST,
        S_A,
        S_B_PREP,
        S_CROSS,
        S_SS,
        S_C_PREP,
        S_LAUNCH,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_EDGE,
        PH_CTR,
        PH_DIST,
        PH_B,
        PH_LEN,
        PH_C
    } t_phase;

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_su_op;

    typedef struct packed {
        logic       start;
        t_su_op     op;
        logic [5:0] qbits;
    } t_su_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_su_sts;

    // varying axis of a cube edge
    function automatic logic [1:0] edge_axis(input logic [3:0] e);
        logic [1:0] ax;
        unique case (e) inside
            4'd0, 4'd1, 4'd2, 4'd3:  ax = 2'd0;
            4'd4, 4'd5, 4'd6, 4'd7:  ax = 2'd2;
            default:                 ax = 2'd1;
        endcase
        return ax;
    endfunction

    // fixed coordinates of a cube edge, {z, y, x}
    function automatic logic [2:0] edge_fix(input logic [3:0] e);
        logic [2:0] f;
        unique case (e) inside
            4'd1, 4'd5:  f = 3'b010;
            4'd2, 4'd10: f = 3'b100;
            4'd3:        f = 3'b110;
            4'd6, 4'd9:  f = 3'b001;
            4'd7:        f = 3'b011;
            4'd11:       f = 3'b101;
            default:     f = 3'b000;
        endcase
        return f;
    endfunction

    // coordinate j of the point at parameter t on edge e
    function automatic logic [16:0] pt_coord(input logic [3:0] e, input logic [16:0] t,
                                             input logic [1:0] j);
        logic [1:0]  ax;
        logic [2:0]  fx;
        logic [16:0] v;
        ax = edge_axis(e);
        fx = edge_fix(e);
        if (j == 2'd3)
            v = '0;
        else if (j == ax)
            v = t;
        else
            v = fx[j] ? ONE_Q16 : 17'd0;
        return v;
    endfunction

endpackage

// File: hw/rtl/pcsc_stream_if.sv
// ----------------------------------------------------------------------------
// pcsc_stream_if: valid/ready word channel
// Carries one word per handshake; source drives valid and data, sink ready.
// ----------------------------------------------------------------------------
interface pcsc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/pcsc_serial_unit.sv
// ----------------------------------------------------------------------------
// pcsc_serial_unit: shared bit-serial divider and square root
// Restoring division, one quotient bit a cycle; digit-by-digit root, one bit
// a cycle over a 64-bit radicand.
// ----------------------------------------------------------------------------
module pcsc_serial_unit
    import pcsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_su_req            i_req,
    input  logic [RAD_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output t_su_sts            o_sts,
    output logic [RES_W-1:0]   o_res
);

    localparam logic [5:0] SqrtSteps = 6'(RAD_W / 2);

    logic               r_busy;
    logic               r_done;
    t_su_op             r_op;
    logic [5:0]         r_cnt;
    logic [RAD_W-1:0]   r_sh;
    logic [DEN_W+2:0]   r_rem;
    logic [RES_W-1:0]   r_q;
    logic [DEN_W-1:0]   r_den;

    logic [DEN_W+2:0]   w_dt, w_st, w_trial;
    logic               w_dge, w_sge;
    logic               w_go;

    assign w_go    = i_req.start && !r_busy;
    assign w_dt    = {r_rem[DEN_W+1:0], r_sh[RAD_W-1]};
    assign w_dge   = w_dt >= {3'b000, r_den};
    assign w_st    = {r_rem[DEN_W:0], r_sh[RAD_W-1:RAD_W-2]};
    assign w_trial = {1'b0, r_q[DEN_W-1:0], 2'b01};
    assign w_sge   = w_st >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (w_go) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == OP_DIV) ? i_req.qbits : SqrtSteps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_op  <= i_req.op;
            r_q   <= '0;
            r_den <= i_den;
            if (i_req.op == OP_DIV) begin
                r_rem <= (DEN_W+3)'(i_num >> i_req.qbits);
                r_sh  <= i_num << (7'd64 - {1'b0, i_req.qbits});
            end else begin
                r_rem <= '0;
                r_sh  <= i_num;
            end
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                r_sh  <= r_sh << 1;
                r_rem <= w_dge ? (w_dt - {3'b000, r_den}) : w_dt;
                r_q   <= {r_q[RES_W-2:0], w_dge};
            end else begin
                r_sh  <= r_sh << 2;
                r_rem <= w_sge ? (w_st - w_trial) : w_st;
                r_q   <= {r_q[RES_W-2:0], w_sge};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_res      = r_q;

endmodule

// File: hw/rtl/plane_cube_slice_corners.sv
// ----------------------------------------------------------------------------
// plane_cube_slice_corners: slice square of a plane through the unit cube
// Intersects a plane with the cube edges and emits the square's corners.
// ----------------------------------------------------------------------------
// One plane word (normal and offset, Q4.12) goes in; the block walks the twelve
// cube edges, keeps every hit (a vertex counts once per edge that hits it),
// averages the hits to a centre, picks the first farthest hit and emits four
// corner words (Q4.16, saturated) of a square whose diagonals are
// WINDOW_SIZE_Q16 long: corners 0/2 lie along the farthest direction, 1/3
// along its cross with the normal. With under three hits, or all hits on one
// spot, a single word with valid_res low and last high comes out instead. One
// plane is worked at a time. A plane that cuts the cube goes through an edge
// scan with one quotient per hit, then three centre quotients, a distance
// search over the hits, two roots and six vector quotients, nearly all of it
// in the one shared bit-serial divide/root unit. A plane that gives the lone
// invalid word is done right after the edge scan, or after the distance
// search when all hits coincide. The next plane word is taken as soon as the
// last corner sits in the output register.
// ----------------------------------------------------------------------------
module plane_cube_slice_corners
    import pcsc_pkg::*;
#(
    parameter int WINDOW_SIZE_Q16 = WINDOW_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcsc_stream_if.sink   i_plane,
    pcsc_stream_if.source o_corner
);

    localparam logic signed [32:0] WinMul  = 33'(WINDOW_SIZE_Q16);
    localparam logic signed [32:0] HalfMul = 33'(WINDOW_SIZE_Q16 / 2);

    // sequencer
    t_state r_state, n_state;
    t_phase r_ph;

    // plane
    logic signed [15:0] r_n [3];
    logic signed [15:0] r_d;

    // hit list: edge number and edge parameter per hit
    logic [3:0]  r_i, r_cnt, r_best;
    logic [3:0]  r_pe [EDGES];
    logic [16:0] r_pt [EDGES];
    logic [19:0] r_sum [3];
    logic [16:0] r_ctr [3];
    logic [1:0]  r_j;
    logic        r_h;

    // vector work
    logic signed [65:0] r_prod;
    logic [63:0]        r_acc;
    logic [33:0]        r_best_sq;
    logic [16:0]        r_dist;
    logic signed [17:0] r_a  [3];
    logic signed [33:0] r_cr [3];
    logic [31:0]        r_len;
    logic signed [17:0] r_b  [3];
    logic signed [17:0] r_c  [3];

    // serial unit operands
    logic [63:0] r_num;
    logic [31:0] r_den;
    logic [5:0]  r_qb;
    t_su_op      r_op;
    t_su_req     w_req;
    t_su_sts     w_sts;
    logic [47:0] w_res;

    // output side
    logic [1:0]  r_k;
    logic        r_inv;
    logic        r_ov;
    t_out_word   r_out;
    logic        w_in_ready, w_load;

    // edge test
    logic [1:0]         w_ax;
    logic [2:0]         w_fix;
    logic signed [17:0] w_num;
    logic signed [15:0] w_den;
    logic [17:0]        w_num_mag;
    logic [16:0]        w_den_mag;
    logic               w_hit;

    // per-coordinate selects
    logic [16:0]        w_pc, w_ctr_j;
    logic signed [17:0] w_df, w_a_j, w_ap, w_aq;
    logic signed [15:0] w_np, w_nq;
    logic [32:0]        w_crm [3];
    logic [32:0]        w_or;
    logic [1:0]         w_shf;
    logic [30:0]        w_mg [3];
    logic [30:0]        w_mg_j;
    logic signed [33:0] w_cr_j;
    logic [63:0]        w_tot;

    // shared multiplier
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;

    // corner
    logic signed [20:0] w_cv [3];
    logic signed [19:0] w_sat [3];

    pcsc_serial_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    // ---- edge intersection test ----
    always_comb begin
        w_ax  = edge_axis(r_i);
        w_fix = edge_fix(r_i);
        w_num = 18'(r_d);
        if (w_fix[0]) w_num = w_num - 18'(r_n[0]);
        if (w_fix[1]) w_num = w_num - 18'(r_n[1]);
        if (w_fix[2]) w_num = w_num - 18'(r_n[2]);
        case (w_ax)
            2'd0:    w_den = r_n[0];
            2'd1:    w_den = r_n[1];
            default: w_den = r_n[2];
        endcase
        w_num_mag = (w_num < 0) ? 18'(-w_num) : 18'(w_num);
        w_den_mag = (w_den < 0) ? 17'(-18'(w_den)) : 17'(w_den);
        w_hit = (w_den != 0) && ((w_num == 0) || ((w_num < 0) == (w_den < 0)))
                && (w_num_mag <= {1'b0, w_den_mag});
    end

    // ---- coordinate selects ----
    always_comb begin
        w_pc = pt_coord(r_pe[r_i], r_pt[r_i], r_j);
        case (r_j)
            2'd0:    begin w_ctr_j = r_ctr[0]; w_a_j = r_a[0]; w_cr_j = r_cr[0]; end
            2'd1:    begin w_ctr_j = r_ctr[1]; w_a_j = r_a[1]; w_cr_j = r_cr[1]; end
            2'd2:    begin w_ctr_j = r_ctr[2]; w_a_j = r_a[2]; w_cr_j = r_cr[2]; end
            default: begin w_ctr_j = '0;       w_a_j = '0;     w_cr_j = '0;      end
        endcase
        w_df = signed'({1'b0, w_pc}) - signed'({1'b0, w_ctr_j});
        // cross operands: component j = a[p]*n[q] - a[q]*n[p]
        case (r_j)
            2'd0:    begin w_ap = r_a[1]; w_nq = r_n[2]; w_aq = r_a[2]; w_np = r_n[1]; end
            2'd1:    begin w_ap = r_a[2]; w_nq = r_n[0]; w_aq = r_a[0]; w_np = r_n[2]; end
            default: begin w_ap = r_a[0]; w_nq = r_n[1]; w_aq = r_a[1]; w_np = r_n[0]; end
        endcase
        for (int j = 0; j < 3; j++)
            w_crm[j] = (r_cr[j] < 0) ? 33'(-r_cr[j]) : 33'(r_cr[j]);
        w_or = w_crm[0] | w_crm[1] | w_crm[2];
        // smallest shift that brings the largest magnitude below 2^31
        w_shf = w_or[32] ? 2'd2 : (w_or[31] ? 2'd1 : 2'd0);
        for (int j = 0; j < 3; j++)
            w_mg[j] = 31'(w_crm[j] >> w_shf);
        case (r_j)
            2'd0:    w_mg_j = w_mg[0];
            2'd1:    w_mg_j = w_mg[1];
            2'd2:    w_mg_j = w_mg[2];
            default: w_mg_j = '0;
        endcase
        w_tot = r_acc + r_prod[63:0];
    end

    // ---- shared multiplier operand select ----
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_DIST:   begin w_ma = 33'(w_df); w_mb = 33'(w_df); end
            S_CROSS:  begin
                w_ma = r_h ? 33'(w_aq) : 33'(w_ap);
                w_mb = r_h ? 33'(w_np) : 33'(w_nq);
            end
            S_SS:     begin w_ma = signed'({2'b00, w_mg_j}); w_mb = signed'({2'b00, w_mg_j}); end
            S_B_PREP: begin
                w_ma = (w_a_j < 0) ? 33'(-w_a_j) : 33'(w_a_j);
                w_mb = WinMul;
            end
            S_C_PREP: begin w_ma = signed'({2'b00, w_mg_j}); w_mb = HalfMul; end
            default:  ;
        endcase
        w_mp = w_ma * w_mb;
    end

    // ---- corner arithmetic and saturation ----
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_k[1])
                w_cv[j] = signed'({4'b0000, r_ctr[j]}) - 21'(r_k[0] ? r_c[j] : r_b[j]);
            else
                w_cv[j] = signed'({4'b0000, r_ctr[j]}) + 21'(r_k[0] ? r_c[j] : r_b[j]);
            if (w_cv[j] > 21'sd524287)
                w_sat[j] = 20'sd524287;
            else if (w_cv[j] < -21'sd524288)
                w_sat[j] = -20'sd524288;
            else
                w_sat[j] = 20'(w_cv[j]);
        end
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_plane.valid) n_state = S_EDGE;
            S_EDGE: begin
                if (r_i == 4'(EDGES))
                    n_state = (r_cnt < 4'(MIN_POINTS)) ? S_EMIT : S_CTR;
                else if (w_hit)
                    n_state = S_LAUNCH;
            end
            S_CTR:    n_state = S_LAUNCH;
            S_DIST: begin
                if (r_i == r_cnt)
                    n_state = (r_best_sq == '0) ? S_EMIT : S_LAUNCH;
            end
            S_A:      n_state = S_B_PREP;
            S_B_PREP: n_state = S_LAUNCH;
            S_CROSS:  if (r_j == 2'd2 && r_h) n_state = S_SS;
            S_SS:     if (r_j == 2'd3) n_state = S_LAUNCH;
            S_C_PREP: n_state = S_LAUNCH;
            S_LAUNCH: n_state = S_WAIT;
            S_WAIT: begin
                if (w_sts.done) begin
                    unique case (r_ph)
                        PH_EDGE: n_state = S_EDGE;
                        PH_CTR:  n_state = (r_j == 2'd2) ? S_DIST : S_CTR;
                        PH_DIST: n_state = S_A;
                        PH_B:    n_state = (r_j == 2'd2) ? S_CROSS : S_B_PREP;
                        PH_LEN:  n_state = (w_res[31:0] == '0) ? S_EMIT : S_C_PREP;
                        PH_C:    n_state = (r_j == 2'd2) ? S_EMIT : S_C_PREP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EMIT: begin
                if (w_load && (r_inv || r_k == 2'd3))
                    n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // ---- control outputs ----
    always_comb begin
        w_in_ready  = (r_state == S_IDLE);
        w_load      = (r_state == S_EMIT) && (!r_ov || o_corner.ready);
        w_req.start = (r_state == S_LAUNCH);
        w_req.op    = r_op;
        w_req.qbits = r_qb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_plane.valid) begin
                    r_n[0] <= i_plane.data.normal_x;
                    r_n[1] <= i_plane.data.normal_y;
                    r_n[2] <= i_plane.data.normal_z;
                    r_d    <= i_plane.data.plane_offset;
                    r_i    <= '0;
                    r_cnt  <= '0;
                    r_k    <= '0;
                    r_inv  <= 1'b0;
                    for (int j = 0; j < 3; j++) r_sum[j] <= '0;
                end
            end
            S_EDGE: begin
                if (r_i == 4'(EDGES)) begin
                    r_j <= '0;
                    if (r_cnt < 4'(MIN_POINTS)) r_inv <= 1'b1;
                end else if (w_hit) begin
                    r_num <= 64'(w_num_mag) << 16;
                    r_den <= 32'(w_den_mag);
                    r_qb  <= QB_EDGE;
                    r_op  <= OP_DIV;
                    r_ph  <= PH_EDGE;
                end else begin
                    r_i <= r_i + 4'd1;
                end
            end
            S_CTR: begin
                r_num <= 64'(r_sum[r_j]);
                r_den <= 32'(r_cnt);
                r_qb  <= QB_CTR;
                r_op  <= OP_DIV;
                r_ph  <= PH_CTR;
            end
            S_DIST: begin
                if (r_i == r_cnt) begin
                    if (r_best_sq == '0) r_inv <= 1'b1;
                    r_num <= 64'(r_best_sq);
                    r_op  <= OP_SQRT;
                    r_ph  <= PH_DIST;
                end else begin
                    // each hit: three squares, then compare
                    r_prod <= w_mp;
                    r_j    <= r_j + 2'd1;
                    case (r_j)
                        2'd1:    r_acc <= r_prod[63:0];
                        2'd2:    r_acc <= w_tot;
                        2'd3: begin
                            r_i <= r_i + 4'd1;
                            if (w_tot[33:0] > r_best_sq) begin
                                r_best_sq <= w_tot[33:0];
                                r_best    <= r_i;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_A: begin
                for (int j = 0; j < 3; j++)
                    r_a[j] <= signed'({1'b0, pt_coord(r_pe[r_i], r_pt[r_i], 2'(j))})
                              - signed'({1'b0, r_ctr[j]});
                r_j <= '0;
            end
            S_B_PREP: begin
                r_num <= 64'(w_mp);
                r_den <= 32'({r_dist, 1'b0});
                r_qb  <= QB_VEC;
                r_op  <= OP_DIV;
                r_ph  <= PH_B;
            end
            S_CROSS: begin
                r_h <= ~r_h;
                if (!r_h) begin
                    r_prod <= w_mp;
                end else begin
                    r_cr[r_j] <= 34'(r_prod - w_mp);
                    r_j       <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                end
            end
            S_SS: begin
                r_prod <= w_mp;
                r_j    <= r_j + 2'd1;
                case (r_j)
                    2'd1:    r_acc <= r_prod[63:0];
                    2'd2:    r_acc <= w_tot;
                    2'd3: begin
                        r_num <= w_tot;
                        r_op  <= OP_SQRT;
                        r_ph  <= PH_LEN;
                    end
                    default: ;
                endcase
            end
            S_C_PREP: begin
                r_num <= 64'(w_mp);
                r_den <= r_len;
                r_qb  <= QB_VEC;
                r_op  <= OP_DIV;
                r_ph  <= PH_C;
            end
            S_WAIT: begin
                if (w_sts.done) begin
                    unique case (r_ph)
                        PH_EDGE: begin
                            r_pe[r_cnt] <= r_i;
                            r_pt[r_cnt] <= w_res[16:0];
                            for (int j = 0; j < 3; j++)
                                r_sum[j] <= r_sum[j]
                                            + 20'(pt_coord(r_i, w_res[16:0], 2'(j)));
                            r_cnt <= r_cnt + 4'd1;
                            r_i   <= r_i + 4'd1;
                        end
                        PH_CTR: begin
                            r_ctr[r_j] <= w_res[16:0];
                            if (r_j == 2'd2) begin
                                r_j       <= '0;
                                r_i       <= '0;
                                r_best_sq <= '0;
                                r_best    <= '0;
                            end else begin
                                r_j <= r_j + 2'd1;
                            end
                        end
                        PH_DIST: begin
                            r_dist <= w_res[16:0];
                            r_i    <= r_best;
                        end
                        PH_B: begin
                            r_b[r_j] <= (w_a_j < 0) ? -18'(w_res) : 18'(w_res);
                            r_j      <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                            r_h      <= 1'b0;
                        end
                        PH_LEN: begin
                            r_len <= w_res[31:0];
                            r_j   <= '0;
                            // degenerate cross: corners 1 and 3 fall on the centre
                            if (w_res[31:0] == '0)
                                for (int j = 0; j < 3; j++) r_c[j] <= '0;
                        end
                        PH_C: begin
                            r_c[r_j] <= (w_cr_j < 0) ? -18'(w_res) : 18'(w_res);
                            r_j      <= (r_j == 2'd2) ? 2'd0 : r_j + 2'd1;
                        end
                        default: ;
                    endcase
                end
            end
            S_EMIT: begin
                if (w_load) r_k <= r_k + 2'd1;
            end
            default: ;
        endcase
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (w_load)
            r_ov <= 1'b1;
        else if (o_corner.ready)
            r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.valid_res    <= !r_inv;
            r_out.corner_index <= r_inv ? 2'd0 : r_k;
            r_out.corner_x     <= r_inv ? 20'sd0 : w_sat[0];
            r_out.corner_y     <= r_inv ? 20'sd0 : w_sat[1];
            r_out.corner_z     <= r_inv ? 20'sd0 : w_sat[2];
            r_out.last         <= r_inv || (r_k == 2'd3);
        end
    end

    assign i_plane.ready  = w_in_ready;
    assign o_corner.valid = r_ov;
    assign o_corner.data  = r_out;

`ifndef ASSERT_OFF
    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_sts.busy)
        else $error("serial unit started while busy");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt <= 4'(EDGES)))
        else $error("hit count beyond edge count");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_corner.valid && o_corner.data.last) |->
        (o_corner.data.corner_index == 2'd3 || !o_corner.data.valid_res))
        else $error("last flag on an inner corner");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_WAIT))
        else $error("unit result arrived outside wait");
`endif

endmodule
